// ===== hdl/cdh_pkg.sv =====
// cdh_pkg: shared types and constants for the start/stop delay histogram
// used by cdh_ctrl, cdh_dp and coincidence_delay_histogram
package cdh_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 40;
  localparam int unsigned TimeW = 62;
  localparam int unsigned DelayW = 40;
  localparam int unsigned QuotW = 41;
  localparam int unsigned UsedW = 11;
  localparam int unsigned OutCountW = 32;

  localparam logic [CfgIdxW-1:0] RegStartCh = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStopCh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxDelay = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPitch = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGate = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBinsUsed = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic clr_step;   // clear one histogram row
    logic pair_init;  // start walking the ring
    logic pair_load;  // read data valid, compute delay
    logic div_start;  // begin division
    logic div_step;   // one quotient bit
    logic hist_rd;    // read histogram bin
    logic hist_wr;    // write back incremented bin
    logic next_slot;  // advance ring walk
    logic store;      // write start to ring
    logic read_out;   // capture read result
    logic ev_out;     // capture event result
  } cdh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic is_read;
    logic is_stop;
    logic is_start;
    logic walk_done;
    logic pair_ok;    // delay inside window
    logic div_done;
    logic bin_ok;     // bin and gate pass
  } cdh_sts_t;

endpackage

// ===== hdl/coincidence_delay_histogram.sv =====
// coincidence_delay_histogram: top level, joins sequencer and datapath
// depends on cdh_pkg, cdh_ctrl, cdh_dp, cdh_ram
//
// Start events store their timestamp in a ring of RECENT_STARTS entries; a
// stop event walks every stored start and histograms the delay into a memory
// of HIST_BINS saturating counters. One item is handled at a time. For each
// stored start inside the delay window the bin number comes from a
// one-bit-per-cycle divider. After reset the histogram memory is cleared
// entry by entry before the first item enters.
module coincidence_delay_histogram import cdh_pkg::*; #(
  parameter int unsigned RECENT_STARTS = 64,
  parameter int unsigned HIST_BINS = 1024,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  logic [2:0]           channel_i,
  input  logic [TimeW-1:0]     timestamp_i,
  input  logic [9:0]           bin_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OutCountW-1:0] count_o,
  output logic                 start_overflow_o
);

  cdh_cmd_t cmd;
  cdh_sts_t sts;

  cdh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cdh_dp #(
    .RecentStarts(RECENT_STARTS),
    .HistBins    (HIST_BINS),
    .CountBits   (COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .channel_i       (channel_i),
    .timestamp_i     (timestamp_i),
    .bin_index_i     (bin_index_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .count_o         (count_o),
    .start_overflow_o(start_overflow_o)
  );

endmodule

// ===== hdl/cdh_ram.sv =====
// cdh_ram: generic single-port write, single-port read ram with registered read
// no dependencies
module cdh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/cdh_ctrl.sv =====
// cdh_ctrl: sequencer for the delay histogram
// depends on cdh_pkg
module cdh_ctrl import cdh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  cdh_sts_t sts_i,
  output cdh_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    StClear = 10'b0000000001,
    StIdle  = 10'b0000000010,
    StDisp  = 10'b0000000100,
    StRdWt  = 10'b0000001000,
    StFetch = 10'b0000010000,
    StPair  = 10'b0000100000,
    StDiv   = 10'b0001000000,
    StHist  = 10'b0010000000,
    StIncr  = 10'b0100000000,
    StDone  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   rd_item_q, rd_item_d;

  assign out_valid_o = out_valid_q;
  // a new item may enter once the previous result is out or leaving
  assign in_stall_o = !(state_q == StIdle && (!out_valid_q || !out_stall_i));

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_item_d = rd_item_q;
    cmd_o = '0;
    case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.load = 1'b1;
          state_d = StDisp;
        end
      end
      StDisp: begin
        if (sts_i.is_read) begin
          cmd_o.hist_rd = 1'b1;
          rd_item_d = 1'b1;
          state_d = StHist;
        end else if (sts_i.is_stop) begin
          cmd_o.pair_init = 1'b1;
          state_d = StFetch;
        end else begin
          state_d = StDone;
        end
      end
      StFetch: begin
        // ram read issued, data next cycle
        if (sts_i.walk_done) state_d = StDone;
        else state_d = StRdWt;
      end
      StRdWt: begin
        cmd_o.pair_load = 1'b1;
        state_d = StPair;
      end
      StPair: begin
        if (sts_i.pair_ok) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          cmd_o.next_slot = 1'b1;
          state_d = StFetch;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = StIncr;
      end
      StIncr: begin
        if (sts_i.bin_ok) begin
          cmd_o.hist_rd = 1'b1;
          rd_item_d = 1'b0;
          state_d = StHist;
        end else begin
          cmd_o.next_slot = 1'b1;
          state_d = StFetch;
        end
      end
      StHist: begin
        if (rd_item_q) begin
          cmd_o.read_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end else begin
          cmd_o.hist_wr = 1'b1;
          cmd_o.next_slot = 1'b1;
          state_d = StFetch;
        end
      end
      StDone: begin
        cmd_o.store = sts_i.is_start;
        cmd_o.ev_out = 1'b1;
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      out_valid_q <= 1'b0;
      rd_item_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      rd_item_q <= rd_item_d;
    end
  end

endmodule

// ===== hdl/cdh_dp.sv =====
// cdh_dp: datapath with ring of starts, divider, histogram memory and config
// depends on cdh_pkg and cdh_ram
module cdh_dp import cdh_pkg::*; #(
  parameter int unsigned RecentStarts = 64,
  parameter int unsigned HistBins = 1024,
  parameter int unsigned CountBits = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 kind_i,
  input  logic [2:0]           channel_i,
  input  logic [TimeW-1:0]     timestamp_i,
  input  logic [9:0]           bin_index_i,
  input  cdh_cmd_t             cmd_i,
  output cdh_sts_t             sts_o,
  output logic [OutCountW-1:0] count_o,
  output logic                 start_overflow_o
);

  localparam int unsigned RingAw = (RecentStarts > 1) ? $clog2(RecentStarts) : 1;
  localparam int unsigned FillW = $clog2(RecentStarts + 1);
  localparam int unsigned HistAw = (HistBins > 1) ? $clog2(HistBins) : 1;
  localparam int unsigned DivCntW = $clog2(QuotW + 1);
  localparam logic [FillW-1:0] FillFull = FillW'(RecentStarts);
  localparam logic [RingAw-1:0] LastSlot = RingAw'(RecentStarts - 1);
  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [HistAw:0] BinsLim = (HistAw + 1)'(HistBins);

  // configuration
  logic [2:0]        start_ch_q, stop_ch_q;
  logic [DelayW-1:0] offset_q, max_q, pitch_q, gate_q;
  logic [UsedW-1:0]  used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ch_q <= 3'd0;
      stop_ch_q <= 3'd1;
      offset_q <= '0;
      max_q <= DelayW'(1000000);
      pitch_q <= DelayW'(1000);
      gate_q <= DelayW'(1000);
      used_q <= UsedW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStartCh:  start_ch_q <= cfg_data_i[2:0];
        RegStopCh:   stop_ch_q <= cfg_data_i[2:0];
        RegOffset:   offset_q <= cfg_data_i;
        RegMaxDelay: max_q <= cfg_data_i;
        RegPitch:    pitch_q <= cfg_data_i;
        RegGate:     gate_q <= cfg_data_i;
        RegBinsUsed: used_q <= cfg_data_i[UsedW-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  logic             kind_q;
  logic [2:0]       ch_q;
  logic [TimeW-1:0] ts_q;
  logic [9:0]       idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      ch_q <= channel_i;
      ts_q <= timestamp_i;
      idx_q <= bin_index_i;
    end
  end

  // ring control
  logic [RingAw-1:0] head_q, walk_q;
  logic [FillW-1:0]  fill_q, walk_n_q;
  logic [TimeW-1:0]  ring_rdata;
  logic              is_stop, walk_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      walk_q <= '0;
      walk_n_q <= '0;
    end else begin
      if (cmd_i.pair_init) begin
        walk_q <= '0;
        walk_n_q <= '0;
      end else if (cmd_i.next_slot) begin
        walk_q <= walk_q + 1'b1;
        walk_n_q <= walk_n_q + 1'b1;
      end
      if (cmd_i.store) begin
        head_q <= (head_q == LastSlot) ? '0 : head_q + 1'b1;
        if (fill_q != FillFull) fill_q <= fill_q + 1'b1;
      end
    end
  end

  assign is_stop = (ch_q == stop_ch_q);
  assign walk_done = (walk_n_q >= fill_q);

  // outside the ring walk the ram read port looks at the head slot
  logic [RingAw-1:0] ring_raddr;
  assign ring_raddr = (is_stop && !walk_done) ? walk_q : head_q;

  cdh_ram #(.Width(TimeW), .Depth(1 << RingAw)) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(head_q),
    .wdata_i(ts_q),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  // delay computation
  logic [TimeW-1:0]  delay_w;
  logic [DelayW-1:0] rel_q;
  logic              pair_ok_q;
  assign delay_w = ts_q - ring_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pair_load) begin
      pair_ok_q <= (ring_rdata <= ts_q) && (delay_w > TimeW'(offset_q))
                   && (delay_w <= TimeW'(max_q));
      rel_q <= DelayW'(delay_w - TimeW'(offset_q));
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DelayW-1:0]  pitch_eff;
  logic [DelayW:0]    rem_q, rem_sh;
  logic [DelayW-1:0]  dvd_q;
  logic [QuotW-1:0]   quot_q;
  logic [DivCntW-1:0] div_cnt_q;
  assign pitch_eff = (pitch_q == '0) ? DelayW'(1) : pitch_q;
  assign rem_sh = {rem_q[DelayW-1:0], dvd_q[DelayW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dvd_q <= rel_q;
      quot_q <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step && div_cnt_q != DivCntW'(DelayW)) begin
      dvd_q <= {dvd_q[DelayW-2:0], 1'b0};
      div_cnt_q <= div_cnt_q + 1'b1;
      if (rem_sh >= {1'b0, pitch_eff}) begin
        rem_q <= rem_sh - {1'b0, pitch_eff};
        quot_q <= {quot_q[QuotW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quot_q <= {quot_q[QuotW-2:0], 1'b0};
      end
    end
  end

  logic [HistAw:0] used_eff;
  assign used_eff = ({{(32 - UsedW){1'b0}}, used_q} > 32'(HistBins)) ? BinsLim
                    : (HistAw + 1)'(used_q);
  logic bin_ok;
  assign bin_ok = (QuotW'(used_eff) > quot_q) && (rem_q[DelayW-1:0] < gate_q);

  // histogram memory, cleared by a sweep after reset
  logic [HistAw:0]      clr_q;
  logic [HistAw-1:0]    h_raddr, h_waddr, bin_q;
  logic [CountBits-1:0] h_rdata, h_wdata;
  logic                 h_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_rd) bin_q <= h_raddr;
  end

  assign h_raddr = kind_q ? HistAw'(idx_q) : HistAw'(quot_q);
  assign h_we = cmd_i.clr_step || cmd_i.hist_wr;
  assign h_waddr = cmd_i.clr_step ? clr_q[HistAw-1:0] : bin_q;
  assign h_wdata = cmd_i.clr_step ? '0
                   : ((h_rdata == CountMax) ? h_rdata : h_rdata + 1'b1);

  cdh_ram #(.Width(CountBits), .Depth(1 << HistAw)) u_hist (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  // event pair count
  logic [OutCountW-1:0] binned_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) binned_q <= '0;
    else if (cmd_i.hist_wr) binned_q <= binned_q + 1'b1;
  end

  // results
  logic idx_in;
  logic old_in_win;
  assign idx_in = ({22'd0, idx_q} < 32'(HistBins));
  assign old_in_win = (ring_rdata > ts_q) || ((ts_q - ring_rdata) <= TimeW'(max_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_out) begin
      start_overflow_o <= 1'b0;
      if (!idx_in) count_o <= '0;
      else if (CountBits > OutCountW && |(h_rdata >> OutCountW)) count_o <= '1;
      else count_o <= OutCountW'(h_rdata);
    end else if (cmd_i.ev_out) begin
      count_o <= binned_q;
      start_overflow_o <= cmd_i.store && (fill_q == FillFull) && old_in_win;
    end
  end

  assign sts_o.clr_done = (clr_q == (HistAw + 1)'((1 << HistAw) - 1));
  assign sts_o.is_read = kind_q;
  assign sts_o.is_stop = is_stop;
  assign sts_o.is_start = !kind_q && (ch_q == start_ch_q);
  assign sts_o.walk_done = walk_done;
  assign sts_o.pair_ok = pair_ok_q;
  assign sts_o.div_done = (div_cnt_q == DivCntW'(DelayW));
  assign sts_o.bin_ok = bin_ok;

endmodule
